// ===== hdl/cec_pkg.sv =====
// types, widths and helpers shared by the circle collision pipeline
// no dependencies
package cec_pkg;

  localparam int VW  = 24;
  localparam int TW  = 16;
  localparam int KW  = 42;
  localparam int PW  = 50;
  localparam int NW  = 92;
  localparam int DW  = 67;
  localparam int QW  = 41;
  localparam int TRW = DW + QW;
  localparam int RND_SH = 14;
  localparam logic [TW-1:0] TIME_STEP_RESET = 16'd1092;
  localparam logic [QW-1:0] DELTA_CLAMP = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    logic signed [23:0] pos_a_x;
    logic signed [23:0] pos_a_y;
    logic [22:0]        radius_a;
    logic signed [23:0] vel_a_x;
    logic signed [23:0] vel_a_y;
    logic [15:0]        mass_a;
    logic signed [23:0] pos_b_x;
    logic signed [23:0] pos_b_y;
    logic [22:0]        radius_b;
    logic signed [23:0] vel_b_x;
    logic signed [23:0] vel_b_y;
    logic [15:0]        mass_b;
  } item_t;

  typedef struct packed {
    logic               hit;
    logic signed [23:0] new_vel_a_x;
    logic signed [23:0] new_vel_a_y;
    logic signed [23:0] new_vel_b_x;
    logic signed [23:0] new_vel_b_y;
    logic signed [23:0] new_pos_a_x;
    logic signed [23:0] new_pos_a_y;
    logic signed [23:0] new_pos_b_x;
    logic signed [23:0] new_pos_b_y;
  } res_t;

  typedef struct packed {
    item_t      item;
    logic       hit;
    logic       go;
    logic [3:0] neg;
  } side_t;

  function automatic logic signed [VW-1:0] sat_val(input logic signed [43:0] v);
    logic signed [43:0] hi;
    logic signed [43:0] lo;
    hi = 44'sd8388607;
    lo = -44'sd8388608;
    if (v > hi) sat_val = 24'sh7fffff;
    else if (v < lo) sat_val = 24'sh800000;
    else sat_val = v[VW-1:0];
  endfunction

endpackage

// ===== hdl/cec_in_if.sv =====
// input channel of the collision pipeline: one circle pair per beat
// depends on cec_pkg
interface cec_in_if;
  logic           valid;
  logic           ready;
  cec_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/cec_out_if.sv =====
// output channel of the collision pipeline: one response per beat
// depends on cec_pkg
interface cec_out_if;
  logic          valid;
  logic          ready;
  cec_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/cec_front.sv =====
// front stages: distances, hit test, projections and split products
// depends on cec_pkg
module cec_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  cec_pkg::item_t              in_item,
  output logic                        out_valid,
  output logic [3:0][cec_pkg::NW-1:0] num,
  output logic [cec_pkg::DW-1:0]      den,
  output cec_pkg::side_t              side
);
  import cec_pkg::*;

  logic v1, v2, v3, v4;
  item_t it1, it2, it3, it4;
  logic signed [24:0] dx1, dy1, dx2, dy2;
  logic [23:0] rs1;
  logic [48:0] dxx2, dyy2;
  logic [47:0] rss2;
  logic signed [48:0] dxa2, dya2, dxb2, dyb2;
  logic [49:0] d2_3;
  logic hit3, hit4;
  logic signed [50:0] pd3;
  logic [16:0] msum3;
  logic [3:0][KW-1:0] k3;
  logic [3:0] neg3, neg4;
  logic go4;
  logic [3:0][3:0][45:0] pp4;
  logic [1:0][41:0] dp4;

  logic signed [49:0] sqx, sqy;
  logic signed [49:0] pa, pb;
  logic signed [50:0] pd_c;
  logic [49:0] d2_c;
  logic [24:0] adx, ady;
  logic [39:0] t0, t1, t2, t3;
  logic [50:0] apd_w;
  logic [PW-1:0] apd;

  always_comb begin
    sqx = 50'(dx1) * 50'(dx1);
    sqy = 50'(dy1) * 50'(dy1);
    d2_c = 50'(dxx2) + 50'(dyy2);
    pa = 50'(dxa2) + 50'(dya2);
    pb = 50'(dxb2) + 50'(dyb2);
    pd_c = 51'(pb) - 51'(pa);
    adx = dx2[24] ? 25'(-dx2) : 25'(dx2);
    ady = dy2[24] ? 25'(-dy2) : 25'(dy2);
    t0 = 40'(it2.mass_b) * 40'(adx);
    t1 = 40'(it2.mass_b) * 40'(ady);
    t2 = 40'(it2.mass_a) * 40'(adx);
    t3 = 40'(it2.mass_a) * 40'(ady);
    apd_w = pd3[50] ? 51'(-pd3) : 51'(pd3);
    apd = apd_w[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
    if (en) begin
      it1 <= in_item;
      dx1 <= $signed({in_item.pos_a_x[23], in_item.pos_a_x})
           - $signed({in_item.pos_b_x[23], in_item.pos_b_x});
      dy1 <= $signed({in_item.pos_a_y[23], in_item.pos_a_y})
           - $signed({in_item.pos_b_y[23], in_item.pos_b_y});
      rs1 <= 24'(in_item.radius_a) + 24'(in_item.radius_b);

      it2 <= it1;
      dx2 <= dx1;
      dy2 <= dy1;
      dxx2 <= sqx[48:0];
      dyy2 <= sqy[48:0];
      rss2 <= 48'(rs1) * 48'(rs1);
      dxa2 <= 49'(dx1) * 49'($signed(it1.vel_a_x));
      dya2 <= 49'(dy1) * 49'($signed(it1.vel_a_y));
      dxb2 <= 49'(dx1) * 49'($signed(it1.vel_b_x));
      dyb2 <= 49'(dy1) * 49'($signed(it1.vel_b_y));

      it3 <= it2;
      d2_3 <= d2_c;
      hit3 <= d2_c <= 50'(rss2);
      pd3 <= pd_c;
      msum3 <= 17'(it2.mass_a) + 17'(it2.mass_b);
      k3[0] <= {t0, 2'b00};
      k3[1] <= {t1, 2'b00};
      k3[2] <= {t2, 2'b00};
      k3[3] <= {t3, 2'b00};
      neg3[0] <= pd_c[50] ^ dx2[24];
      neg3[1] <= pd_c[50] ^ dy2[24];
      neg3[2] <= (!pd_c[50] && (pd_c != '0)) ^ dx2[24];
      neg3[3] <= (!pd_c[50] && (pd_c != '0)) ^ dy2[24];

      it4 <= it3;
      hit4 <= hit3;
      go4 <= hit3 && (d2_3 != '0) && (msum3 != '0);
      neg4 <= neg3;
      for (int i = 0; i < 4; i++) begin
        pp4[i][0] <= 46'(apd[49:25]) * 46'(k3[i][41:21]);
        pp4[i][1] <= 46'(apd[49:25]) * 46'(k3[i][20:0]);
        pp4[i][2] <= 46'(apd[24:0]) * 46'(k3[i][41:21]);
        pp4[i][3] <= 46'(apd[24:0]) * 46'(k3[i][20:0]);
      end
      dp4[0] <= 42'(msum3) * 42'(d2_3[49:25]);
      dp4[1] <= 42'(msum3) * 42'(d2_3[24:0]);

      for (int i = 0; i < 4; i++) begin
        num[i] <= (NW'(pp4[i][0]) << 46) + (NW'(pp4[i][1]) << 25)
                + (NW'(pp4[i][2]) << 21) + NW'(pp4[i][3]);
      end
      den <= (DW'(dp4[0]) << 25) + DW'(dp4[1]);
      side.item <= it4;
      side.hit <= hit4;
      side.go <= go4;
      side.neg <= neg4;
    end
  end

endmodule

// ===== hdl/cec_div.sv =====
// pipelined restoring divider, one quotient bit per stage, four lanes
// sharing one divisor; depends on cec_pkg
module cec_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [3:0][cec_pkg::NW-1:0] num,
  input  logic [cec_pkg::DW-1:0]      den,
  input  cec_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [3:0][cec_pkg::QW-1:0] quo,
  output logic [3:0]                  clp,
  output cec_pkg::side_t              out_side
);
  import cec_pkg::*;

  logic [QW:0] vld;
  logic [QW:0][3:0][NW-1:0] rem;
  logic [QW:0][3:0][QW-1:0] qq;
  logic [QW:0][3:0] cc;
  logic [QW:0][DW-1:0] dd;
  side_t sd [QW+1];

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_valid;
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        rem[0][i] <= num[i];
        qq[0][i] <= '0;
        cc[0][i] <= TRW'(num[i]) >= {den, {QW{1'b0}}};
      end
      dd[0] <= den;
      sd[0] <= in_side;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [TRW:0] sh;
    logic [3:0][TRW:0] df;
    logic [3:0][QW-1:0] qn;

    always_comb begin
      sh = (TRW+1)'(dd[k]) << B;
      for (int i = 0; i < 4; i++) begin
        df[i] = (TRW+1)'(rem[k][i]) - sh;
        qn[i] = qq[k][i];
        qn[i][B] = !df[i][TRW];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (en) vld[k+1] <= vld[k];
      if (en) begin
        for (int i = 0; i < 4; i++) begin
          rem[k+1][i] <= df[i][TRW] ? rem[k][i] : df[i][NW-1:0];
          qq[k+1][i] <= qn[i];
          cc[k+1][i] <= cc[k][i];
        end
        dd[k+1] <= dd[k];
        sd[k+1] <= sd[k];
      end
    end
  end

  assign out_valid = vld[QW];
  assign quo = qq[QW];
  assign clp = cc[QW];
  assign out_side = sd[QW];

endmodule

// ===== hdl/cec_back.sv =====
// back stages: rounding, velocity update, position advance, saturation
// depends on cec_pkg
module cec_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [cec_pkg::TW-1:0]      time_step,
  input  logic                        in_valid,
  input  logic [3:0][cec_pkg::QW-1:0] quo,
  input  logic [3:0]                  clp,
  input  cec_pkg::side_t              in_side,
  output logic                        out_valid,
  output cec_pkg::res_t               res
);
  import cec_pkg::*;

  logic v1, v2;
  side_t s1, s2;
  logic [3:0][VW-1:0] nv1, nv2;
  logic [3:0][39:0] prod2;

  logic [3:0][VW-1:0] vin, pin;
  logic [3:0][QW-1:0] lo;
  logic [3:0][QW:0] lo1;
  logic [3:0][QW-1:0] qr;
  logic signed [3:0][43:0] dlt;
  logic [3:0][VW-1:0] vnext;
  logic [3:0][VW-1:0] av;
  logic [3:0][40:0] stp;
  logic signed [3:0][43:0] psum;
  logic [3:0][VW-1:0] pnext;

  always_comb begin
    vin[0] = in_side.item.vel_a_x;
    vin[1] = in_side.item.vel_a_y;
    vin[2] = in_side.item.vel_b_x;
    vin[3] = in_side.item.vel_b_y;
    pin[0] = s2.item.pos_a_x;
    pin[1] = s2.item.pos_a_y;
    pin[2] = s2.item.pos_b_x;
    pin[3] = s2.item.pos_b_y;
    for (int i = 0; i < 4; i++) begin
      lo[i] = (clp[i] || quo[i] > DELTA_CLAMP) ? DELTA_CLAMP : quo[i];
      lo1[i] = (QW+1)'(lo[i]) + (QW+1)'(1);
      qr[i] = lo1[i][QW:1];
      dlt[i] = in_side.neg[i] ? -44'(qr[i]) : 44'(qr[i]);
      vnext[i] = in_side.go ? sat_val(44'($signed(vin[i])) + dlt[i]) : vin[i];
      av[i] = nv1[i][VW-1] ? VW'(-nv1[i]) : nv1[i];
      stp[i] = (41'(prod2[i]) + 41'(1 << (RND_SH - 1))) >> RND_SH;
      psum[i] = nv2[i][VW-1] ? 44'($signed(pin[i])) - 44'(stp[i])
                             : 44'($signed(pin[i])) + 44'(stp[i]);
      pnext[i] = s2.hit ? sat_val(psum[i]) : pin[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
    if (en) begin
      s1 <= in_side;
      nv1 <= vnext;
      s2 <= s1;
      nv2 <= nv1;
      for (int i = 0; i < 4; i++) prod2[i] <= 40'(av[i]) * 40'(time_step);
      res.hit <= s2.hit;
      res.new_vel_a_x <= nv2[0];
      res.new_vel_a_y <= nv2[1];
      res.new_vel_b_x <= nv2[2];
      res.new_vel_b_y <= nv2[3];
      res.new_pos_a_x <= pnext[0];
      res.new_pos_a_y <= pnext[1];
      res.new_pos_b_x <= pnext[2];
      res.new_pos_b_y <= pnext[3];
    end
  end

endmodule

// ===== hdl/circle_elastic_collision.sv =====
// top level of the two-circle elastic collision pipeline
// depends on cec_pkg, cec_in_if, cec_out_if, cec_front, cec_div, cec_back
//
// One circle pair enters per clock unless the output stalls, and passes 5 front
// stages for distance, hit test and split products, 42 stages of the
// bit-per-stage divider that forms the velocity change, and 3 back stages for
// rounding, the position advance and saturation. The whole pipeline holds while
// a finished response waits on the output, so pair.ready follows result.ready
// whenever a response is pending. time_step resets to 1092; the user must write
// it through cfg_we / cfg_data only while the pipeline is empty (not enforced).
module circle_elastic_collision (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [cec_pkg::TW-1:0] cfg_data,
  cec_in_if.sink                 pair,
  cec_out_if.source              result
);
  import cec_pkg::*;

  logic [TW-1:0] time_step;
  logic en;
  logic fv, dv;
  logic [3:0][NW-1:0] num;
  logic [DW-1:0] den;
  side_t fside, dside;
  logic [3:0][QW-1:0] quo;
  logic [3:0] clp;

  assign en = !result.valid || result.ready;
  assign pair.ready = en;

  always_ff @(posedge clk) begin
    if (rst) time_step <= TIME_STEP_RESET;
    else if (cfg_we) time_step <= cfg_data;
  end

  cec_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(pair.valid), .in_item(pair.data),
    .out_valid(fv), .num(num), .den(den), .side(fside)
  );

  cec_div u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(fv), .num(num), .den(den), .in_side(fside),
    .out_valid(dv), .quo(quo), .clp(clp), .out_side(dside)
  );

  cec_back u_back (
    .clk(clk), .rst(rst), .en(en), .time_step(time_step),
    .in_valid(dv), .quo(quo), .clp(clp), .in_side(dside),
    .out_valid(result.valid), .res(result.data)
  );

endmodule

// ===== hdl/cec_check.sv =====
// port-level checks for circle_elastic_collision, attached by bind
// depends on cec_pkg
module cec_check (
  input logic          clk,
  input logic          rst,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input cec_pkg::res_t out_data
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("response valid right after reset");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("not ready with empty output");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled response changed");

endmodule

bind circle_elastic_collision cec_check u_check (
  .clk(clk), .rst(rst), .in_ready(pair.ready),
  .out_valid(result.valid), .out_ready(result.ready), .out_data(result.data)
);

// ===== test/tb_circle_elastic_collision.sv =====
`timescale 1ns / 100ps
// testbench for circle_elastic_collision: directed and random circle pairs, checked
// against a bit-accurate response predictor; depends on cec_pkg, cec_in_if, cec_out_if
module tb_circle_elastic_collision;
  import cec_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [TW-1:0] cfg_data = '0;

  cec_in_if pair_if ();
  cec_out_if res_if ();

  circle_elastic_collision u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .pair     (pair_if),
    .result   (res_if)
  );

  always #4 clk = ~clk;

  res_t response_q[$];
  longint unsigned step_model = TIME_STEP_RESET;
  int fails = 0;
  bit no_idle = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;
  string field_name[9] = '{"hit", "new_vel_a_x", "new_vel_a_y", "new_vel_b_x",
    "new_vel_b_y", "new_pos_a_x", "new_pos_a_y", "new_pos_b_x", "new_pos_b_y"};

  initial begin
    pair_if.valid = 1'b0;
    pair_if.data = '0;
    res_if.ready = 1'b0;
  end

  function automatic longint unsigned mag(longint signed v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint signed sat24(longint signed v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint signed vel_share(longint unsigned m, longint signed pd,
      longint signed dc, longint unsigned ms, longint unsigned d2);
    logic [127:0] p;
    longint unsigned q;
    bit neg;
    neg = (pd < 0) != (dc < 0);
    p = 128'(mag(pd)) * 128'(64'd4 * m * mag(dc));
    p = p / 128'(ms);
    p = p / 128'(d2);
    if (p > (128'd1 << 40)) p = 128'd1 << 40;
    q = (p[63:0] + 64'd1) >> 1;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint signed advance_pos(longint signed p, longint signed v);
    longint unsigned s;
    s = (mag(v) * step_model + 64'd8192) >> 14;
    return sat24(v < 0 ? p - longint'(s) : p + longint'(s));
  endfunction

  function automatic res_t predict_response(item_t it);
    res_t r;
    longint signed ax, ay, bx, by, avx, avy, bvx, bvy, dx, dy, rs, d2, pd;
    longint signed nvax, nvay, nvbx, nvby;
    longint unsigned ma, mb, ms;
    ax = longint'(it.pos_a_x); ay = longint'(it.pos_a_y);
    bx = longint'(it.pos_b_x); by = longint'(it.pos_b_y);
    avx = longint'(it.vel_a_x); avy = longint'(it.vel_a_y);
    bvx = longint'(it.vel_b_x); bvy = longint'(it.vel_b_y);
    ma = longint'(it.mass_a); mb = longint'(it.mass_b); ms = ma + mb;
    dx = ax - bx; dy = ay - by;
    rs = longint'(it.radius_a) + longint'(it.radius_b);
    d2 = dx * dx + dy * dy;
    nvax = avx; nvay = avy; nvbx = bvx; nvby = bvy;
    r.hit = d2 <= rs * rs;
    r.new_pos_a_x = it.pos_a_x; r.new_pos_a_y = it.pos_a_y;
    r.new_pos_b_x = it.pos_b_x; r.new_pos_b_y = it.pos_b_y;
    if (r.hit) begin
      if (d2 != 0 && ms != 0) begin
        pd = (dx * bvx + dy * bvy) - (dx * avx + dy * avy);
        nvax = sat24(avx + vel_share(mb, pd, dx, ms, d2));
        nvay = sat24(avy + vel_share(mb, pd, dy, ms, d2));
        nvbx = sat24(bvx + vel_share(ma, -pd, dx, ms, d2));
        nvby = sat24(bvy + vel_share(ma, -pd, dy, ms, d2));
      end
      r.new_pos_a_x = 24'(advance_pos(ax, nvax));
      r.new_pos_a_y = 24'(advance_pos(ay, nvay));
      r.new_pos_b_x = 24'(advance_pos(bx, nvbx));
      r.new_pos_b_y = 24'(advance_pos(by, nvby));
    end
    r.new_vel_a_x = 24'(nvax); r.new_vel_a_y = 24'(nvay);
    r.new_vel_b_x = 24'(nvbx); r.new_vel_b_y = 24'(nvby);
    return r;
  endfunction

  function automatic void unpack_res(res_t r, output longint f[9]);
    f[0] = longint'(r.hit);
    f[1] = longint'(r.new_vel_a_x); f[2] = longint'(r.new_vel_a_y);
    f[3] = longint'(r.new_vel_b_x); f[4] = longint'(r.new_vel_b_y);
    f[5] = longint'(r.new_pos_a_x); f[6] = longint'(r.new_pos_a_y);
    f[7] = longint'(r.new_pos_b_x); f[8] = longint'(r.new_pos_b_y);
  endfunction

  // result beat check
  always @(posedge clk) begin
    longint e[9];
    longint a[9];
    res_t exp_r;
    if (!rst && res_if.valid && res_if.ready) begin
      if (response_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, res_if.data);
        fails++;
      end else begin
        exp_r = response_q.pop_front();
        unpack_res(exp_r, e);
        unpack_res(res_if.data, a);
        for (int i = 0; i < 9; i++)
          if (e[i] != a[i]) begin
            $display("%0t: %s expected %0d actual %0d", $time, field_name[i], e[i], a[i]);
            fails++;
          end
      end
    end
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if ((pair_if.valid && pair_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    if (no_idle) begin
      res_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 15);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  task automatic send_pair(item_t it);
    int gap;
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      pair_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
    pair_if.valid = 1'b1;
    pair_if.data = it;
    do @(posedge clk); while (!pair_if.ready);
    response_q.push_back(predict_response(it));
  endtask

  task automatic write_time_step(logic [TW-1:0] v);
    @(negedge clk);
    pair_if.valid = 1'b0;
    wait (response_q.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    step_model = longint'(v);
  endtask

  function automatic logic signed [23:0] rnd_val();
    logic signed [23:0] v;
    v = 24'($urandom);
    return v >>> $urandom_range(0, 23);
  endfunction

  function automatic item_t rnd_pair();
    item_t it;
    logic [319:0] raw;
    int k;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    if ($urandom_range(0, 9) < 7) begin
      // near pair that mostly overlaps
      k = $urandom_range(0, 21);
      it.pos_a_x = rnd_val();
      it.pos_a_y = rnd_val();
      it.pos_b_x = 24'(it.pos_a_x + $signed(24'($urandom_range(0, 2 ** (k + 1)))) - (2 ** k));
      it.pos_b_y = 24'(it.pos_a_y + $signed(24'($urandom_range(0, 2 ** (k + 1)))) - (2 ** k));
      it.radius_a = 23'($urandom_range(0, 2 ** (k + 1)));
      it.radius_b = 23'($urandom_range(0, 2 ** (k + 1)));
      it.vel_a_x = rnd_val(); it.vel_a_y = rnd_val();
      it.vel_b_x = rnd_val(); it.vel_b_y = rnd_val();
      it.mass_a = 16'($urandom_range(1, 65535) >> $urandom_range(0, 15));
      it.mass_b = 16'($urandom_range(1, 65535) >> $urandom_range(0, 15));
    end
    if (it.mass_a == 0) it.mass_a = 16'd1;
    if (it.mass_b == 0) it.mass_b = 16'd1;
    return it;
  endfunction

  task automatic test_directed();
    item_t it;
    it = '0;
    send_pair(it);
    it.mass_a = 1; it.mass_b = 1;
    it.vel_a_x = 24'sh7fffff; it.vel_b_y = 24'sh800000;
    send_pair(it);
    it = '0;
    it.pos_a_x = 24'sh7fffff; it.pos_a_y = 24'sh7fffff;
    it.pos_b_x = 24'sh800000; it.pos_b_y = 24'sh800000;
    it.radius_a = 23'h7fffff; it.radius_b = 23'h7fffff;
    it.vel_a_x = 24'sh7fffff; it.vel_a_y = 24'sh7fffff;
    it.vel_b_x = 24'sh800000; it.vel_b_y = 24'sh800000;
    it.mass_a = 16'hffff; it.mass_b = 16'hffff;
    send_pair(it);
    it.radius_a = 0; it.radius_b = 0;
    send_pair(it);
    it.mass_a = 1; it.radius_a = 23'h7fffff;
    send_pair(it);
    it = '0;
    it.pos_a_x = 24'sd256; it.pos_b_x = -24'sd256;
    it.radius_a = 23'd256; it.radius_b = 23'd256;
    it.vel_a_x = -24'sd512; it.vel_b_x = 24'sd512;
    it.mass_a = 1; it.mass_b = 1;
    send_pair(it);
    it.radius_b = 23'd255;
    send_pair(it);
    it.radius_b = 23'd256; it.mass_a = 0; it.mass_b = 0;
    send_pair(it);
    it.mass_a = 0; it.mass_b = 16'hffff;
    send_pair(it);
    it.mass_a = 16'hffff; it.mass_b = 0;
    send_pair(it);
    it.pos_b_x = it.pos_a_x; it.pos_b_y = it.pos_a_y; it.mass_a = 3; it.mass_b = 5;
    it.vel_a_y = 24'sh800000; it.vel_b_y = 24'sh7fffff;
    send_pair(it);
    it.pos_a_x = 24'sh7fffff; it.pos_b_x = 24'sh7fff00; it.radius_a = 23'd1000;
    it.vel_a_x = 24'sh7fffff; it.vel_b_x = 24'sh800000; it.vel_a_y = 0; it.vel_b_y = 0;
    send_pair(it);
    it.pos_a_x = 24'sh800000; it.pos_b_x = 24'sh800100;
    send_pair(it);
    it.pos_a_x = 24'sd1; it.pos_a_y = 24'sd1; it.pos_b_x = 0; it.pos_b_y = 0;
    it.mass_a = 16'hffff; it.mass_b = 1;
    send_pair(it);
  endtask

  task automatic test_random(int n);
    repeat (n) send_pair(rnd_pair());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(150);
    write_time_step(16'd0);
    test_directed();
    test_random(150);
    write_time_step(16'hffff);
    test_directed();
    test_random(150);
    write_time_step(16'($urandom_range(0, 65535)));
    test_random(150);
    write_time_step(16'd1);
    test_random(100);
    write_time_step(TIME_STEP_RESET);
    no_idle = 1'b1;
    test_random(200);
    @(negedge clk);
    pair_if.valid = 1'b0;
    wait (response_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
